@@ rtl/lsre_pkg.sv @@
// Shared constants, action codes and controller/datapath command and status types
// for the link-state route engine. Depends on nothing.
`default_nettype none

package lsre_pkg;

   localparam int NODE_COUNT_DEF = 256;
   localparam int UNREACH_DEF    = 24'hFFFFFF;

   localparam int ACTION_W = 2;
   localparam int NODE_W   = 8;
   localparam int SEQ_W    = 32;
   localparam int COST_W   = 16;
   localparam int DIST_W   = 24;

   localparam logic [COST_W-1:0] LINK_NONE = '1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_HEADER  = 2'd0,
      ACT_PAIR    = 2'd1,
      ACT_COMPUTE = 2'd2,
      ACT_QUERY   = 2'd3
   } action_type;

   typedef struct packed {
      logic capture;
      logic clear_step;
      logic dispatch;
      logic seq_rd;
      logic hdr_decide;
      logic row_step;
      logic pair_write;
      logic comp_start;
      logic init_step;
      logic sweep_start;
      logic issue;
      logic settle;
      logic hop_start;
      logic order_rd;
      logic pred_rd;
      logic hop_rd;
      logic hop_skip;
      logic hop_wr;
      logic qry_rd;
      logic qry_take;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic       clear_done;
      logic       idx_end;
      logic       iter_end;
      logic       pipe_busy;
      logic       hdr_newer;
      logic       pred_none;
      logic       rsp_free;
      action_type act;
   } status_type;

endpackage

`default_nettype wire

@@ rtl/lsre_if.sv @@
// Request and response channel interfaces (valid/ready plus payload).
// Depends on lsre_pkg.
`default_nettype none

interface lsre_req_if;
   import lsre_pkg::*;
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [NODE_W-1:0]   node;
   logic [SEQ_W-1:0]    seq_number;
   logic [COST_W-1:0]   cost;
   modport source (output valid, action, node, seq_number, cost, input ready);
   modport sink   (input valid, action, node, seq_number, cost, output ready);
endinterface

interface lsre_rsp_if;
   import lsre_pkg::*;
   logic              valid;
   logic              ready;
   logic              accepted;
   logic [NODE_W-1:0] hop;
   logic [DIST_W-1:0] distance;
   logic              reachable;
   modport source (output valid, accepted, hop, distance, reachable, input ready);
   modport sink   (input valid, accepted, hop, distance, reachable, output ready);
endinterface

`default_nettype wire

@@ rtl/link_state_route_engine_core.sv @@
// Top level of the link-state route engine: sequencer plus datapath.
// Depends on lsre_pkg, lsre_if, lsre_ctrl and lsre_dpath.
`default_nettype none

// Link-state route engine. Each request transfer carries one action and yields
// exactly one response transfer. Header: accepted when its sequence number is
// newer than the stored one for the origin; the origin's cost row is then
// cleared and opened for the pair transfers that follow. Pair: writes a link cost
// from the open origin. Compute: Dijkstra from own_node over the cost matrix,
// lowest index wins distance ties, then next hops follow the predecessor chains.
// Query: returns hop, distance and reachability for a destination.
// After reset the block first sweeps the cost matrix to unreachable, one entry a
// cycle, with the request side held off; own_node writes are taken during that
// sweep. An accepted header clears the origin's row, one row entry per cycle.
// In a compute, every settle step streams one cost row through the single read
// port of the matrix memory, one neighbor a cycle, while the next minimum is
// tracked.
// The response is held in an output register, so a new request is taken while
// an earlier response still waits for its transfer.
module link_state_route_engine_core #(
   parameter int NODE_COUNT       = lsre_pkg::NODE_COUNT_DEF,
   parameter int UNREACHABLE_DIST = lsre_pkg::UNREACH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   lsre_req_if.sink                    req_chan,
   lsre_rsp_if.source                  rsp_chan,
   input  logic                        csr_write_enable,
   input  logic [lsre_pkg::NODE_W-1:0] csr_write_data
);
   import lsre_pkg::*;

   cmd_type    cmd;
   status_type stat;

   // sequencer: one action at a time
   lsre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // tables, relaxation pipe and response register
   lsre_dpath #(
      .NODE_COUNT       (NODE_COUNT),
      .UNREACHABLE_DIST (UNREACHABLE_DIST)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_action       (req_chan.action),
      .req_node         (req_chan.node),
      .req_seq_number   (req_chan.seq_number),
      .req_cost         (req_chan.cost),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_accepted     (rsp_chan.accepted),
      .rsp_hop          (rsp_chan.hop),
      .rsp_distance     (rsp_chan.distance),
      .rsp_reachable    (rsp_chan.reachable)
   );

endmodule

`default_nettype wire

@@ rtl/lsre_ctrl.sv @@
// Sequencer for the link-state route engine: walks each action through its steps
// and drives the datapath commands. Depends on lsre_pkg.
`default_nettype none

module lsre_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  lsre_pkg::status_type   stat,
   output lsre_pkg::cmd_type      cmd
);
   import lsre_pkg::*;

   typedef enum logic [12:0] {
      ST_RESET_CLR = 13'b0000000000001,
      ST_IDLE      = 13'b0000000000010,
      ST_DISPATCH  = 13'b0000000000100,
      ST_HDR_CHK   = 13'b0000000001000,
      ST_ROW_CLR   = 13'b0000000010000,
      ST_INIT      = 13'b0000000100000,
      ST_SCAN      = 13'b0000001000000,
      ST_HOP_ORD   = 13'b0000010000000,
      ST_HOP_PRED  = 13'b0000100000000,
      ST_HOP_CHK   = 13'b0001000000000,
      ST_HOP_WR    = 13'b0010000000000,
      ST_QRY_WAIT  = 13'b0100000000000,
      ST_FINISH    = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_RESET_CLR: begin
            if (stat.clear_done) state_in = ST_IDLE;
            else cmd.clear_step = 1'b1;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            cmd.dispatch = 1'b1;
            case (stat.act)
               ACT_HEADER: begin
                  cmd.seq_rd = 1'b1;
                  state_in   = ST_HDR_CHK;
               end
               ACT_PAIR: begin
                  cmd.pair_write = 1'b1;
                  state_in       = ST_FINISH;
               end
               ACT_COMPUTE: begin
                  cmd.comp_start = 1'b1;
                  state_in       = ST_INIT;
               end
               ACT_QUERY: begin
                  cmd.qry_rd = 1'b1;
                  state_in   = ST_QRY_WAIT;
               end
               default: state_in = ST_FINISH;
            endcase
         end
         ST_HDR_CHK: begin
            cmd.hdr_decide = 1'b1;
            state_in = stat.hdr_newer ? ST_ROW_CLR : ST_FINISH;
         end
         ST_ROW_CLR: begin
            if (stat.idx_end) state_in = ST_FINISH;
            else cmd.row_step = 1'b1;
         end
         ST_INIT: begin
            if (stat.idx_end) begin
               cmd.sweep_start = 1'b1;
               state_in        = ST_SCAN;
            end else begin
               cmd.init_step = 1'b1;
            end
         end
         ST_SCAN: begin
            if (!stat.idx_end) begin
               cmd.issue = 1'b1;
            end else if (!stat.pipe_busy) begin
               if (stat.iter_end) begin
                  cmd.hop_start = 1'b1;
                  state_in      = ST_HOP_ORD;
               end else begin
                  cmd.settle = 1'b1;
               end
            end
         end
         ST_HOP_ORD: begin
            if (stat.iter_end) begin
               state_in = ST_FINISH;
            end else begin
               cmd.order_rd = 1'b1;
               state_in     = ST_HOP_PRED;
            end
         end
         ST_HOP_PRED: begin
            cmd.pred_rd = 1'b1;
            state_in    = ST_HOP_CHK;
         end
         ST_HOP_CHK: begin
            if (stat.pred_none) begin
               cmd.hop_skip = 1'b1;
               state_in     = ST_HOP_ORD;
            end else begin
               cmd.hop_rd = 1'b1;
               state_in   = ST_HOP_WR;
            end
         end
         ST_HOP_WR: begin
            cmd.hop_wr = 1'b1;
            state_in   = ST_HOP_ORD;
         end
         ST_QRY_WAIT: begin
            cmd.qry_take = 1'b1;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_RESET_CLR;
      else state_ff <= state_in;
   end

endmodule

`default_nettype wire

@@ rtl/lsre_dpath.sv @@
// Datapath of the link-state route engine: cost matrix, sequence table, route
// tables, the relaxation pipe and the result registers. Depends on lsre_pkg.
`default_nettype none

module lsre_dpath #(
   parameter int NODE_COUNT       = lsre_pkg::NODE_COUNT_DEF,
   parameter int UNREACHABLE_DIST = lsre_pkg::UNREACH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lsre_pkg::cmd_type             cmd,
   output lsre_pkg::status_type          stat,
   input  logic [lsre_pkg::ACTION_W-1:0] req_action,
   input  logic [lsre_pkg::NODE_W-1:0]   req_node,
   input  logic [lsre_pkg::SEQ_W-1:0]    req_seq_number,
   input  logic [lsre_pkg::COST_W-1:0]   req_cost,
   input  logic                          csr_write_enable,
   input  logic [lsre_pkg::NODE_W-1:0]   csr_write_data,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic                          rsp_accepted,
   output logic [lsre_pkg::NODE_W-1:0]   rsp_hop,
   output logic [lsre_pkg::DIST_W-1:0]   rsp_distance,
   output logic                          rsp_reachable
);
   import lsre_pkg::*;

   localparam int IW         = $clog2(NODE_COUNT);
   localparam int CLR_W      = 2 * IW + 1;
   localparam int LINK_DEPTH = 1 << (2 * IW);
   localparam logic [DIST_W-1:0] UNREACH = DIST_W'(UNREACHABLE_DIST);
   localparam logic [IW:0] IDX_NONE = {1'b1, {IW{1'b0}}};

   // captured item
   logic [ACTION_W-1:0] act_ff;
   logic [NODE_W-1:0]   node_ff;
   logic [SEQ_W-1:0]    seq_ff;
   logic [COST_W-1:0]   cost_ff;
   logic [NODE_W-1:0]   own_ff;

   logic [IW-1:0] origin_ff;
   logic          pairs_en_ff;

   logic [CLR_W-1:0] clr_ff;
   logic [IW:0]      idx_ff;
   logic [IW:0]      iter_ff;

   logic                  b_valid_ff;
   logic [IW-1:0]         b_j_ff;
   logic                  found_ff;
   logic [DIST_W-1:0]     best_ff;
   logic [IW-1:0]         bu_ff;
   logic [IW-1:0]         u_ff;
   logic [DIST_W-1:0]     du_ff;
   logic [NODE_COUNT-1:0] settled_ff;
   logic [IW-1:0]         v_ff;
   logic [IW:0]           p_ff;

   logic              res_acc_ff;
   logic [NODE_W-1:0] res_hop_ff;
   logic [DIST_W-1:0] res_dist_ff;
   logic              res_reach_ff;
   logic              rsp_valid_ff;
   logic              rsp_acc_ff;
   logic [NODE_W-1:0] rsp_hop_ff;
   logic [DIST_W-1:0] rsp_dist_ff;
   logic              rsp_reach_ff;

   // memories
   logic [COST_W-1:0] link_mem  [LINK_DEPTH];
   logic [SEQ_W-1:0]  seq_mem   [NODE_COUNT];
   logic [DIST_W-1:0] dist_mem  [NODE_COUNT];
   logic [IW:0]       pred_mem  [NODE_COUNT];
   logic [IW:0]       hop_mem   [NODE_COUNT];
   logic [IW-1:0]     order_mem [NODE_COUNT];

   logic [COST_W-1:0] link_rd_ff;
   logic [SEQ_W-1:0]  seq_rd_ff;
   logic [DIST_W-1:0] dist_rd_ff;
   logic [IW:0]       pred_rd_ff;
   logic [IW:0]       hop_rd_ff;
   logic [IW-1:0]     order_rd_ff;

   logic              link_we, seq_we, dist_we, pred_we, hop_we;
   logic [2*IW-1:0]   link_wa;
   logic [COST_W-1:0] link_wd;
   logic [IW-1:0]     seq_wa, dist_wa, pred_wa, hop_wa;
   logic [SEQ_W-1:0]  seq_wd;
   logic [DIST_W-1:0] dist_wd;
   logic [IW:0]       pred_wd, hop_wd;
   logic [IW-1:0]     dist_ra, pred_ra, hop_ra;

   logic              node_ok, own_ok, hdr_newer;
   logic [IW-1:0]     node_idx, idx_lo;
   logic              sj, relax_ok, upd;
   logic [DIST_W:0]   cand;
   logic [DIST_W-1:0] new_d;
   logic [IW:0]       new_p;

   assign node_idx  = node_ff[IW-1:0];
   assign idx_lo    = idx_ff[IW-1:0];
   assign node_ok   = {1'b0, node_ff} < (NODE_W+1)'(NODE_COUNT);
   assign own_ok    = {1'b0, own_ff} < (NODE_W+1)'(NODE_COUNT);
   assign hdr_newer = node_ok && (seq_ff > seq_rd_ff);

   // relaxation of one neighbor
   always_comb begin
      sj       = settled_ff[b_j_ff];
      cand     = {1'b0, du_ff} + (DIST_W+1)'(link_rd_ff);
      relax_ok = b_valid_ff && (du_ff < UNREACH) && !sj && (link_rd_ff != LINK_NONE) &&
                 (cand < {1'b0, UNREACH});
      new_d    = dist_rd_ff;
      new_p    = pred_rd_ff;
      upd      = 1'b0;
      if (relax_ok) begin
         if (cand[DIST_W-1:0] < dist_rd_ff) begin
            new_d = cand[DIST_W-1:0];
            new_p = {1'b0, u_ff};
            upd   = 1'b1;
         end else if (cand[DIST_W-1:0] == dist_rd_ff && !pred_rd_ff[IW] &&
                      pred_rd_ff[IW-1:0] > u_ff) begin
            new_p = {1'b0, u_ff};
            upd   = 1'b1;
         end
      end
   end

   // memory port selection
   always_comb begin
      link_we = 1'b0;
      link_wa = {origin_ff, idx_lo};
      link_wd = LINK_NONE;
      if (cmd.clear_step) begin
         link_we = 1'b1;
         link_wa = clr_ff[2*IW-1:0];
      end else if (cmd.row_step) begin
         link_we = 1'b1;
      end else if (cmd.pair_write && pairs_en_ff && node_ok) begin
         link_we = 1'b1;
         link_wa = {origin_ff, node_idx};
         link_wd = cost_ff;
      end

      seq_we = cmd.clear_step || (cmd.hdr_decide && hdr_newer);
      seq_wa = cmd.clear_step ? clr_ff[IW-1:0] : node_idx;
      seq_wd = cmd.clear_step ? '0 : seq_ff;

      dist_we = 1'b0;
      dist_wa = b_j_ff;
      dist_wd = new_d;
      if (cmd.clear_step) begin
         dist_we = 1'b1;
         dist_wa = clr_ff[IW-1:0];
         dist_wd = UNREACH;
      end else if (cmd.init_step) begin
         dist_we = 1'b1;
         dist_wa = idx_lo;
         dist_wd = (own_ok && own_ff == NODE_W'(idx_lo)) ? '0 : UNREACH;
      end else if (upd) begin
         dist_we = 1'b1;
      end

      pred_we = cmd.init_step || upd;
      pred_wa = cmd.init_step ? idx_lo : b_j_ff;
      pred_wd = cmd.init_step ? IDX_NONE : new_p;

      hop_we = 1'b0;
      hop_wa = v_ff;
      hop_wd = (own_ff == NODE_W'(p_ff[IW-1:0])) ? {1'b0, v_ff} : hop_rd_ff;
      if (cmd.clear_step) begin
         hop_we = 1'b1;
         hop_wa = clr_ff[IW-1:0];
         hop_wd = IDX_NONE;
      end else if (cmd.init_step) begin
         hop_we = 1'b1;
         hop_wa = idx_lo;
         hop_wd = IDX_NONE;
      end else if (cmd.hop_wr) begin
         hop_we = 1'b1;
      end

      dist_ra = cmd.issue ? idx_lo : node_idx;
      pred_ra = cmd.issue ? idx_lo : order_rd_ff;
      hop_ra  = cmd.qry_rd ? node_idx : pred_rd_ff[IW-1:0];
   end

   always_ff @(posedge clock) begin
      if (link_we) link_mem[link_wa] <= link_wd;
      link_rd_ff <= link_mem[{u_ff, idx_lo}];
      if (seq_we) seq_mem[seq_wa] <= seq_wd;
      if (cmd.seq_rd) seq_rd_ff <= seq_mem[node_idx];
      if (dist_we) dist_mem[dist_wa] <= dist_wd;
      dist_rd_ff <= dist_mem[dist_ra];
      if (pred_we) pred_mem[pred_wa] <= pred_wd;
      pred_rd_ff <= pred_mem[pred_ra];
      if (hop_we) hop_mem[hop_wa] <= hop_wd;
      hop_rd_ff <= hop_mem[hop_ra];
      if (cmd.settle) order_mem[iter_ff[IW-1:0]] <= bu_ff;
      if (cmd.order_rd) order_rd_ff <= order_mem[iter_ff[IW-1:0]];
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff  <= req_action;
         node_ff <= req_node;
         seq_ff  <= req_seq_number;
         cost_ff <= req_cost;
      end
      if (cmd.hdr_decide && hdr_newer) origin_ff <= node_idx;
      b_j_ff <= idx_lo;
      if (b_valid_ff && !sj && (!found_ff || new_d < best_ff)) begin
         best_ff <= new_d;
         bu_ff   <= b_j_ff;
      end
      if (cmd.comp_start) du_ff <= UNREACH;
      if (cmd.settle) begin
         u_ff  <= bu_ff;
         du_ff <= best_ff;
      end
      if (cmd.pred_rd) v_ff <= order_rd_ff;
      if (cmd.hop_rd) p_ff <= pred_rd_ff;
      if (cmd.dispatch) begin
         res_acc_ff   <= 1'b0;
         res_hop_ff   <= '0;
         res_dist_ff  <= '0;
         res_reach_ff <= 1'b0;
      end
      if (cmd.hdr_decide) res_acc_ff <= hdr_newer;
      if (cmd.qry_take) begin
         if (node_ok) begin
            res_dist_ff  <= dist_rd_ff;
            res_reach_ff <= !hop_rd_ff[IW];
            res_hop_ff   <= hop_rd_ff[IW] ? '0 : NODE_W'(hop_rd_ff[IW-1:0]);
         end else begin
            res_dist_ff <= UNREACH;
         end
      end
      if (cmd.rsp_load) begin
         rsp_acc_ff   <= res_acc_ff;
         rsp_hop_ff   <= res_hop_ff;
         rsp_dist_ff  <= res_dist_ff;
         rsp_reach_ff <= res_reach_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         own_ff       <= '0;
         pairs_en_ff  <= 1'b0;
         clr_ff       <= '0;
         idx_ff       <= '0;
         iter_ff      <= '0;
         b_valid_ff   <= 1'b0;
         found_ff     <= 1'b0;
         settled_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) own_ff <= csr_write_data;
         if (cmd.hdr_decide) pairs_en_ff <= hdr_newer;
         if (cmd.clear_step) clr_ff <= clr_ff + 1'b1;

         if (cmd.hdr_decide || cmd.comp_start || cmd.sweep_start || cmd.settle)
            idx_ff <= '0;
         else if (cmd.row_step || cmd.init_step || cmd.issue)
            idx_ff <= idx_ff + 1'b1;

         if (cmd.comp_start || cmd.hop_start)
            iter_ff <= '0;
         else if (cmd.settle || cmd.hop_skip || cmd.hop_wr)
            iter_ff <= iter_ff + 1'b1;

         b_valid_ff <= cmd.issue;

         if (cmd.sweep_start || cmd.settle)
            found_ff <= 1'b0;
         else if (b_valid_ff && !sj)
            found_ff <= 1'b1;

         if (cmd.comp_start) settled_ff <= '0;
         else if (cmd.settle) settled_ff[bu_ff] <= 1'b1;

         if (cmd.rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      stat            = '0;
      stat.clear_done = (clr_ff == CLR_W'(LINK_DEPTH));
      stat.idx_end    = (idx_ff == (IW+1)'(NODE_COUNT));
      stat.iter_end   = (iter_ff == (IW+1)'(NODE_COUNT));
      stat.pipe_busy  = b_valid_ff;
      stat.hdr_newer  = hdr_newer;
      stat.pred_none  = pred_rd_ff[IW];
      stat.rsp_free   = !rsp_valid_ff || rsp_ready;
      stat.act        = action_type'(act_ff);
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_accepted  = rsp_acc_ff;
   assign rsp_hop       = rsp_hop_ff;
   assign rsp_distance  = rsp_dist_ff;
   assign rsp_reachable = rsp_reach_ff;

   a_settle_fresh: assert property (@(posedge clock) disable iff (reset)
      cmd.settle |-> (found_ff && !settled_ff[bu_ff]))
      else $error("settle picked no node or an already settled node");

   a_relax_bound: assert property (@(posedge clock) disable iff (reset)
      upd |-> (new_d < UNREACH))
      else $error("relaxation produced an unreachable distance");

   a_rsp_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a pending result");

   a_iter_range: assert property (@(posedge clock) disable iff (reset)
      iter_ff <= (IW+1)'(NODE_COUNT))
      else $error("iteration counter ran past the node count");

endmodule

`default_nettype wire
